[rtl/sdpg_pkg.sv]
// Shared constants, codes and state types of the STEP/DIR pulse generator.
package sdpg_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int CLOCK_HZ_W = 27;
    localparam int MAX_RATE_W = 16;
    localparam int SPEED_W    = 17;
    localparam int STEPS_W    = 32;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RST = 27'd84000000;
    localparam logic [MAX_RATE_W-1:0] MAX_RATE_RST = 16'd50000;
    localparam logic                  DIR_RST      = 1'b0;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_VELOCITY,
        CMD_MOVE,
        CMD_STOP
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_HZ,
        CFG_MAX_RATE,
        CFG_INIT_DIR
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_D,
        ST_PSC,
        ST_DIV_ARR
    } t_seq_state;

endpackage

[rtl/sdpg_if.sv]
// Valid/ready channel interfaces for command input, status output and register writes.
interface sdpg_in_if;
    import sdpg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic signed [SPEED_W-1:0] speed;
    logic [STEPS_W-1:0]        step_total;
    modport source (output valid, command, speed, step_total, input ready);
    modport sink   (input valid, command, speed, step_total, output ready);
endinterface

interface sdpg_out_if;
    import sdpg_pkg::*;
    logic               valid;
    logic               ready;
    logic               step_level;
    logic               direction;
    logic [STEPS_W-1:0] step_count;
    logic               running;
    logic               target_active;
    logic [TIMER_W-1:0] prescale;
    logic [TIMER_W-1:0] reload;
    modport source (output valid, step_level, direction, step_count, running, target_active,
                    prescale, reload, input ready);
    modport sink   (input valid, step_level, direction, step_count, running, target_active,
                    prescale, reload, output ready);
endinterface

interface sdpg_cfg_if;
    import sdpg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/sdpg_div.sv]
// Restoring divider, one quotient bit per cycle, shared by both divider steps.
module sdpg_div #(
    parameter int DIVISOR_W = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sdpg_pkg::CLOCK_HZ_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]           i_divisor,
    output logic                           o_done,
    output logic [sdpg_pkg::CLOCK_HZ_W-1:0] o_quotient
);
    import sdpg_pkg::*;

    localparam int CNT_W = $clog2(CLOCK_HZ_W + 1);
    localparam logic [CNT_W-1:0] BIT_COUNT = CNT_W'(CLOCK_HZ_W);

    logic                  r_busy, n_busy;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [CLOCK_HZ_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign shifted = {r_rem, r_quo[CLOCK_HZ_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign fits    = ~trial[DIVISOR_W];

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = BIT_COUNT;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_rem = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                n_quo = {r_quo[CLOCK_HZ_W-2:0], fits};
                n_cnt = r_cnt - CNT_W'(1);
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_busy & (r_cnt == '0);
    assign o_quotient = r_quo;

endmodule

[rtl/step_dir_pulse_generator_unit.sv]
// Top level of the STEP/DIR pulse generator: timer, step counter and rate sequencer.
//
//   port    role  carries
//   i_in    sink  command, speed, step_total
//   o_out   src   step_level, direction, step_count, running, target_active, prescale, reload
//   i_cfg   sink  index, data (clock_hz, max_rate, initial_direction)
//
// Tick, stop and ignored commands: result registered in the cycle after the transfer.
// Rate commands: result after two passes of the shared restoring divider
// (one quotient bit per cycle over the 27-bit clock value), run once for the divider
// and once for the reload. Input is held off while a result waits and o_out.ready is low.
// Synchronous active-low reset clears the timer, counts and sequencer; no clearing pass.
module step_dir_pulse_generator_unit #(
    parameter int COUNTER_BITS = sdpg_pkg::COUNTER_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sdpg_in_if.sink      i_in,
    sdpg_cfg_if.sink     i_cfg,
    sdpg_out_if.source   o_out
);
    import sdpg_pkg::*;

    localparam int CB    = COUNTER_BITS;
    localparam int DIV_W = (CB + 1 > MAX_RATE_W + 1) ? CB + 1 : MAX_RATE_W + 1;
    localparam int AW    = (CB > CLOCK_HZ_W) ? CB : CLOCK_HZ_W;
    localparam int SUM_W = AW + 1;
    localparam int PW    = (CB > TIMER_W) ? CB : TIMER_W;
    localparam logic [CB-1:0] CNT_MAX = '1;

    t_seq_state            r_state, n_state;
    logic [CLOCK_HZ_W-1:0] r_clock_hz;
    logic [MAX_RATE_W-1:0] r_max_rate;
    logic [CB-1:0]         r_psc, n_psc;
    logic [CB-1:0]         r_arr, n_arr;
    logic [CB-1:0]         r_psc_cnt, n_psc_cnt;
    logic [CB-1:0]         r_per_cnt, n_per_cnt;
    logic                  r_phase, n_phase;
    logic                  r_enabled, n_enabled;
    logic                  r_pin, n_pin;
    logic                  r_dir, n_dir;
    logic [STEPS_W-1:0]    r_steps_done, n_steps_done;
    logic [STEPS_W-1:0]    r_target_count, n_target_count;
    logic                  r_target_valid, n_target_valid;
    logic [CLOCK_HZ_W-1:0] r_d, n_d;
    logic [CB-1:0]         r_psc_new, n_psc_new;
    logic                  r_out_valid, n_out_valid;

    t_cmd                  cmd;
    logic [SPEED_W-1:0]    speed_bits;
    logic                  neg;
    logic [SPEED_W-1:0]    mag;
    logic                  mag_zero;
    logic [MAX_RATE_W-1:0] rate_clamp;
    logic                  rate_zero;
    logic                  steps_zero;
    logic                  rate_req;
    logic                  in_ready;
    logic                  in_acc;
    logic                  need_div;

    logic                  div_start;
    logic [CLOCK_HZ_W-1:0] div_dividend;
    logic [DIV_W-1:0]      div_divisor;
    logic                  div_done;
    logic [CLOCK_HZ_W-1:0] div_quo;
    logic                  capture_d;
    logic                  capture_psc;
    logic                  commit;

    logic [SUM_W-1:0]      psc_sum;
    logic [SUM_W-1:0]      psc_q;
    logic [SUM_W-1:0]      psc_raw;
    logic [CB-1:0]         psc_calc;
    logic [AW-1:0]         arr_raw;
    logic [CB-1:0]         arr_calc;
    logic [STEPS_W-1:0]    steps_inc;
    logic [PW-1:0]         psc_ext;
    logic [PW-1:0]         arr_ext;

    // command decode
    assign cmd        = t_cmd'(i_in.command);
    assign speed_bits = i_in.speed;
    assign neg        = speed_bits[SPEED_W-1];
    assign mag        = neg ? (SPEED_W'(0) - speed_bits) : speed_bits;
    assign mag_zero   = (mag == '0);
    assign rate_clamp = (mag > SPEED_W'(r_max_rate)) ? r_max_rate : mag[MAX_RATE_W-1:0];
    assign rate_zero  = (rate_clamp == '0);
    assign steps_zero = (i_in.step_total == '0);

    always_comb begin
        case (cmd)
            CMD_VELOCITY: rate_req = !mag_zero && !rate_zero;
            CMD_MOVE:     rate_req = !steps_zero && !neg && !mag_zero && !rate_zero;
            default:      rate_req = 1'b0;
        endcase
    end

    assign in_ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc   = i_in.valid && in_ready;
    assign need_div = in_acc && rate_req;

    // divider and reload arithmetic
    assign psc_sum  = SUM_W'(r_d) + SUM_W'(CNT_MAX);
    assign psc_q    = psc_sum >> CB;
    assign psc_raw  = psc_q - SUM_W'(1);
    assign psc_calc = (psc_raw > SUM_W'(CNT_MAX)) ? CNT_MAX : psc_raw[CB-1:0];

    assign arr_raw  = (div_quo == '0) ? '0 : (AW'(div_quo) - AW'(1));
    assign arr_calc = (arr_raw > AW'(CNT_MAX)) ? CNT_MAX : arr_raw[CB-1:0];

    assign steps_inc = r_steps_done + STEPS_W'(1);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (need_div) n_state = ST_DIV_D;
            ST_DIV_D:   if (div_done) n_state = ST_PSC;
            ST_PSC:     n_state = ST_DIV_ARR;
            ST_DIV_ARR: if (div_done) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_clock_hz;
        div_divisor  = DIV_W'({rate_clamp, 1'b0});
        capture_d    = 1'b0;
        capture_psc  = 1'b0;
        commit       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                div_start = need_div;
            end
            ST_DIV_D: begin
                capture_d = div_done;
            end
            ST_PSC: begin
                div_start    = 1'b1;
                div_dividend = r_d;
                div_divisor  = DIV_W'(psc_calc) + DIV_W'(1);
                capture_psc  = 1'b1;
            end
            ST_DIV_ARR: begin
                commit = div_done;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    sdpg_div #(
        .DIVISOR_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // timer, step count and command effects
    always_comb begin
        logic stop_req;
        stop_req       = 1'b0;
        n_psc          = r_psc;
        n_arr          = r_arr;
        n_psc_cnt      = r_psc_cnt;
        n_per_cnt      = r_per_cnt;
        n_phase        = r_phase;
        n_enabled      = r_enabled;
        n_pin          = r_pin;
        n_dir          = r_dir;
        n_steps_done   = r_steps_done;
        n_target_count = r_target_count;
        n_target_valid = r_target_valid;
        n_d            = r_d;
        n_psc_new      = r_psc_new;

        if (in_acc) begin
            case (cmd)
                CMD_TICK: begin
                    if (r_enabled) begin
                        if (r_psc_cnt >= r_psc) begin
                            n_psc_cnt = '0;
                            if (r_per_cnt >= r_arr) begin
                                n_per_cnt = '0;
                                if (r_phase) begin
                                    n_pin = 1'b0;
                                end else begin
                                    n_pin        = 1'b1;
                                    n_steps_done = steps_inc;
                                    if (r_target_valid && (steps_inc == r_target_count)) begin
                                        n_target_valid = 1'b0;
                                        n_target_count = '0;
                                        n_enabled      = 1'b0;
                                    end
                                end
                                n_phase = !r_phase;
                            end else begin
                                n_per_cnt = r_per_cnt + CB'(1);
                            end
                        end else begin
                            n_psc_cnt = r_psc_cnt + CB'(1);
                        end
                    end
                end
                CMD_VELOCITY: begin
                    if (mag_zero) begin
                        stop_req = 1'b1;
                    end else begin
                        n_dir = !neg;
                        if (rate_zero) stop_req = 1'b1;
                    end
                end
                CMD_MOVE: begin
                    if (!steps_zero) begin
                        if (neg || mag_zero) begin
                            stop_req = 1'b1;
                        end else begin
                            n_target_count = r_steps_done + i_in.step_total;
                            n_target_valid = 1'b1;
                            if (rate_zero) stop_req = 1'b1;
                        end
                    end
                end
                default: begin
                    stop_req = 1'b1;
                end
            endcase
        end

        if (stop_req) begin
            n_enabled      = 1'b0;
            n_phase        = 1'b0;
            n_target_valid = 1'b0;
            n_target_count = '0;
            n_pin          = 1'b0;
        end

        if (capture_d) begin
            n_d = (div_quo == '0) ? CLOCK_HZ_W'(1) : div_quo;
        end
        if (capture_psc) begin
            n_psc_new = psc_calc;
        end
        if (commit) begin
            n_psc     = r_psc_new;
            n_arr     = arr_calc;
            n_psc_cnt = '0;
            n_per_cnt = '0;
            n_phase   = 1'b0;
            n_enabled = 1'b1;
        end
    end

    assign n_out_valid = (r_out_valid && !o_out.ready) || (in_acc && !rate_req) || commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_psc          <= '0;
            r_arr          <= '0;
            r_psc_cnt      <= '0;
            r_per_cnt      <= '0;
            r_phase        <= 1'b0;
            r_enabled      <= 1'b0;
            r_pin          <= 1'b0;
            r_dir          <= DIR_RST;
            r_steps_done   <= '0;
            r_target_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_psc          <= n_psc;
            r_arr          <= n_arr;
            r_psc_cnt      <= n_psc_cnt;
            r_per_cnt      <= n_per_cnt;
            r_phase        <= n_phase;
            r_enabled      <= n_enabled;
            r_pin          <= n_pin;
            r_dir          <= n_dir;
            r_steps_done   <= n_steps_done;
            r_target_valid <= n_target_valid;
            r_out_valid    <= n_out_valid;
        end
        r_target_count <= n_target_count;
        r_d            <= n_d;
        r_psc_new      <= n_psc_new;
    end

    // register writes; initial direction only takes effect through reset, so drop it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RST;
            r_max_rate <= MAX_RATE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_CLOCK_HZ: r_clock_hz <= i_cfg.data[CLOCK_HZ_W-1:0];
                CFG_MAX_RATE: r_max_rate <= i_cfg.data[MAX_RATE_W-1:0];
                CFG_INIT_DIR: r_max_rate <= r_max_rate;
                default:      r_clock_hz <= r_clock_hz;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    assign psc_ext = PW'(r_psc);
    assign arr_ext = PW'(r_arr);

    assign o_out.valid         = r_out_valid;
    assign o_out.step_level    = r_pin;
    assign o_out.direction     = r_dir;
    assign o_out.step_count    = r_steps_done;
    assign o_out.running       = r_enabled;
    assign o_out.target_active = r_target_valid;
    assign o_out.prescale      = psc_ext[TIMER_W-1:0];
    assign o_out.reload        = arr_ext[TIMER_W-1:0];

    a_no_result_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("result pending while rate sequencer busy");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_psc_cnt <= r_psc) && (r_per_cnt <= r_arr))
        else $error("timer counter beyond its limit");

    a_step_on_rising_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_steps_done != $past(r_steps_done))) |->
        ((r_steps_done == $past(r_steps_done) + STEPS_W'(1)) && !$past(r_phase) && r_pin))
        else $error("step count moved outside a rising STEP edge");

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == ST_DIV_D) || (r_state == ST_DIV_ARR)))
        else $error("divider finished outside a divide state");

endmodule
